// ----- hdl/multi_camera_width_aggregator_assert.svh -----
// assertion macros for the multi-camera width aggregator
// needs a clock named clk and a reset named rst in the including module
`ifndef MULTI_CAMERA_WIDTH_AGGREGATOR_ASSERT_SVH
`define MULTI_CAMERA_WIDTH_AGGREGATOR_ASSERT_SVH
`ifndef SYNTH
`define MCWA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCWA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MCWA_ASSERT_SAME(label, ante, cons)
`define MCWA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/mcwa_pkg.sv -----
// shared types and constants of the multi-camera width aggregator
// no dependencies
`default_nettype none
package mcwa_pkg;
  localparam int MAX_SLOTS  = 32;
  localparam int CAMERAS    = 4;
  localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1) > 6 ? $clog2(MAX_SLOTS + 1) : 6;
  localparam int ADDR_W     = $clog2(MAX_SLOTS * CAMERAS) > 0 ?
                              $clog2(MAX_SLOTS * CAMERAS) : 1;
  localparam int DEPTH      = MAX_SLOTS * CAMERAS;
  localparam int SUM_W      = 44;

  // register indexes
  localparam logic [2:0] REG_SLOTS   = 3'd0;
  localparam logic [2:0] REG_LASTCAM = 3'd1;
  localparam logic [2:0] REG_RES0    = 3'd2;
  localparam logic [2:0] REG_RES1    = 3'd3;
  localparam logic [2:0] REG_RES2    = 3'd4;
  localparam logic [2:0] REG_RES3    = 3'd5;
  localparam logic [2:0] REG_OVERLAP = 3'd6;

  typedef struct packed {
    logic [15:0] image_index;
    logic [1:0]  camera;
    logic [15:0] width_pix;
  } in_req_t;

  typedef struct packed {
    logic signed [42:0] total_width;
    logic [15:0]        width_echo;
    logic               complete_found;
  } result_t;
endpackage
`default_nettype wire

// ----- hdl/multi_camera_width_aggregator.sv -----
// top level of the multi-camera width aggregator: sequencer, slot store, apb registers
// depends on mcwa_pkg and multi_camera_width_aggregator_assert.svh
// one request at a time, a new one taken only while idle; busy covers the 16-step
// modulo, the multiply, the store write and the scan (read then add per entry)
// reset (rst, synchronous) restores defaults, clears valid bits and held width; no stall
`default_nettype none
`include "multi_camera_width_aggregator_assert.svh"
module multi_camera_width_aggregator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire mcwa_pkg::in_req_t req,
  output logic                  result_valid,
  output mcwa_pkg::result_t     result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [5:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  // configuration registers
  logic [5:0]         stored_slots;
  logic [1:0]         last_camera;
  logic [23:0]        resolution [4];
  logic signed [39:0] overlap_width;
  logic [2:0]         reg_index;
  assign reg_index = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_slots  <= 6'd1;
      last_camera   <= 2'd0;
      resolution[0] <= 24'd65536;
      resolution[1] <= 24'd65536;
      resolution[2] <= 24'd65536;
      resolution[3] <= 24'd65536;
      overlap_width <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        mcwa_pkg::REG_SLOTS:   stored_slots  <= pwdata[5:0];
        mcwa_pkg::REG_LASTCAM: last_camera   <= pwdata[1:0];
        mcwa_pkg::REG_RES0:    resolution[0] <= pwdata[23:0];
        mcwa_pkg::REG_RES1:    resolution[1] <= pwdata[23:0];
        mcwa_pkg::REG_RES2:    resolution[2] <= pwdata[23:0];
        mcwa_pkg::REG_RES3:    resolution[3] <= pwdata[23:0];
        mcwa_pkg::REG_OVERLAP: overlap_width <= $signed(pwdata[39:0]);
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_index)
      mcwa_pkg::REG_SLOTS:   prdata = {58'd0, stored_slots};
      mcwa_pkg::REG_LASTCAM: prdata = {62'd0, last_camera};
      mcwa_pkg::REG_RES0:    prdata = {40'd0, resolution[0]};
      mcwa_pkg::REG_RES1:    prdata = {40'd0, resolution[1]};
      mcwa_pkg::REG_RES2:    prdata = {40'd0, resolution[2]};
      mcwa_pkg::REG_RES3:    prdata = {40'd0, resolution[3]};
      mcwa_pkg::REG_OVERLAP: prdata = {24'd0, overlap_width};
      default:               prdata = '0;
    endcase
  end

  // sequencer state and working registers
  logic [2:0]                          state;
  logic [15:0]                         idx_sh;
  logic [1:0]                          cam;
  logic [15:0]                         wpix;
  logic [mcwa_pkg::SLOT_CNT_W-1:0]     slots;
  logic [1:0]                          lastc;
  logic [mcwa_pkg::SLOT_CNT_W:0]       rem;
  logic [3:0]                          div_cnt;
  logic [39:0]                         prod;
  logic [mcwa_pkg::SLOT_W-1:0]         scan_slot;
  logic [1:0]                          scan_cam;
  logic signed [mcwa_pkg::SUM_W-1:0]   sum;
  logic signed [mcwa_pkg::SUM_W-1:0]   best;
  logic                                all_set;
  logic                                found;
  logic signed [42:0]                  held_total;

  // clamped settings at request time
  logic [mcwa_pkg::SLOT_CNT_W-1:0] slots_clamped;
  logic [1:0]                      lastc_clamped;
  always_comb begin
    if (stored_slots == 6'd0)
      slots_clamped = mcwa_pkg::SLOT_CNT_W'(1);
    else if (int'(stored_slots) > mcwa_pkg::MAX_SLOTS)
      slots_clamped = mcwa_pkg::SLOT_CNT_W'(mcwa_pkg::MAX_SLOTS);
    else
      slots_clamped = mcwa_pkg::SLOT_CNT_W'(stored_slots);
    if (int'(last_camera) > mcwa_pkg::CAMERAS - 1)
      lastc_clamped = 2'(mcwa_pkg::CAMERAS - 1);
    else
      lastc_clamped = last_camera;
  end

  // one restoring remainder step
  logic [mcwa_pkg::SLOT_CNT_W:0] rem_trial;
  assign rem_trial = {rem[mcwa_pkg::SLOT_CNT_W-1:0], idx_sh[15]};

  // slot store: pixel width and scaled width per entry, with valid bits
  logic [55:0]                 store_mem [mcwa_pkg::DEPTH];
  logic [mcwa_pkg::DEPTH-1:0]  store_valid;
  logic [mcwa_pkg::ADDR_W-1:0] wr_addr;
  logic [mcwa_pkg::ADDR_W-1:0] rd_addr;
  logic [55:0]                 rd_data;
  logic                        rd_valid;
  logic                        wr_en;
  assign wr_addr = mcwa_pkg::ADDR_W'(rem[mcwa_pkg::SLOT_W-1:0]) *
                   mcwa_pkg::ADDR_W'(mcwa_pkg::CAMERAS) + mcwa_pkg::ADDR_W'(cam);
  assign rd_addr = mcwa_pkg::ADDR_W'(scan_slot) *
                   mcwa_pkg::ADDR_W'(mcwa_pkg::CAMERAS) + mcwa_pkg::ADDR_W'(scan_cam);
  assign wr_en = (state == ST_WR) && (int'(cam) < mcwa_pkg::CAMERAS);

  always_ff @(posedge clk) begin
    if (wr_en)
      store_mem[wr_addr] <= {wpix, prod};
    rd_data <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en)
        store_valid[wr_addr] <= 1'b1;
      rd_valid <= store_valid[rd_addr];
    end
  end

  // entry as seen by the scan: an unwritten entry reads as zero
  logic [15:0]                       ent_pix;
  logic signed [mcwa_pkg::SUM_W-1:0] sum_add;
  logic                              all_add;
  logic                              last_cam_hit;
  logic                              last_slot_hit;
  assign ent_pix = rd_valid ? rd_data[55:40] : 16'd0;
  assign sum_add = sum + $signed({4'd0, (rd_valid ? rd_data[39:0] : 40'd0)});
  assign all_add = all_set && (ent_pix != 16'd0);
  assign last_cam_hit = (scan_cam == lastc);
  assign last_slot_hit = ({1'b0, scan_slot} == mcwa_pkg::SLOT_CNT_W'(slots - 1'b1));

  // saturation of the chosen sum to 43 bits
  localparam logic signed [mcwa_pkg::SUM_W-1:0] OUT_MAX = 44'sh3FFFFFFFFFF;
  localparam logic signed [mcwa_pkg::SUM_W-1:0] OUT_MIN = -44'sh40000000000;
  logic signed [42:0] best_sat;
  always_comb begin
    if (best > OUT_MAX)
      best_sat = 43'sh3FFFFFFFFFF;
    else if (best < OUT_MIN)
      best_sat = -43'sh40000000000;
    else
      best_sat = best[42:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held_total   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_DONE);
      case (state)
        ST_IDLE: begin
          if (start) begin
            idx_sh  <= req.image_index;
            cam     <= req.camera;
            wpix    <= req.width_pix;
            slots   <= slots_clamped;
            lastc   <= lastc_clamped;
            rem     <= '0;
            div_cnt <= 4'd0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_trial >= {1'b0, slots})
            rem <= rem_trial - {1'b0, slots};
          else
            rem <= rem_trial;
          idx_sh  <= {idx_sh[14:0], 1'b0};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15)
            state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= 40'(wpix) * 40'(resolution[cam]);
          state <= ST_WR;
        end
        ST_WR: begin
          scan_slot <= '0;
          scan_cam  <= 2'd0;
          sum       <= mcwa_pkg::SUM_W'(overlap_width);
          all_set   <= 1'b1;
          found     <= 1'b0;
          best      <= '0;
          state     <= ST_RD;
        end
        ST_RD: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (!last_cam_hit) begin
            sum      <= sum_add;
            all_set  <= all_add;
            scan_cam <= scan_cam + 2'd1;
            state    <= ST_RD;
          end else begin
            // end of one slot: fold into found flag and best sum
            if (all_add)
              found <= 1'b1;
            if (scan_slot == '0 || sum_add > best)
              best <= sum_add;
            sum       <= mcwa_pkg::SUM_W'(overlap_width);
            all_set   <= 1'b1;
            scan_cam  <= 2'd0;
            scan_slot <= scan_slot + 1'b1;
            state     <= last_slot_hit ? ST_DONE : ST_RD;
          end
        end
        ST_DONE: begin
          if (found)
            held_total <= best_sat;
          result.total_width    <= found ? best_sat : held_total;
          result.width_echo     <= wpix;
          result.complete_found <= found;
          state                 <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  `MCWA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `MCWA_ASSERT_SAME(a_strobe_idle, result_valid, !busy)
  `MCWA_ASSERT_SAME(a_acc_after_rd, state == ST_ACC, $past(state) == ST_RD)
  `MCWA_ASSERT_NEXT(a_done_strobe, state == ST_DONE, result_valid)
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench of the multi-camera width aggregator
// drives requests and apb register writes, predicts every result and compares
// depends on mcwa_pkg and the multi_camera_width_aggregator rtl
`default_nettype none
module tb;
  localparam longint SAT_HI = 64'sd4398046511103;
  localparam longint SAT_LO = -64'sd4398046511104;
  localparam int CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mcwa_pkg::in_req_t req = '0;
  logic result_valid;
  mcwa_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  multi_camera_width_aggregator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always #10 clk = ~clk;

  // shadow copy of block state and registers
  logic [15:0] pix_shadow [mcwa_pkg::DEPTH];
  logic [39:0] scaled_shadow [mcwa_pkg::DEPTH];
  logic signed [42:0] held_width;
  logic [5:0] slots_reg;
  logic [1:0] lastcam_reg;
  logic [23:0] res_reg [4];
  logic signed [39:0] overlap_reg;

  mcwa_pkg::result_t pending_widths [$];
  int errors = 0;
  int idle_pct = 0;
  longint cycles = 0;

  // advance the shadow state by one request and return the expected result
  task automatic aggregate_width(input mcwa_pkg::in_req_t r, output mcwa_pkg::result_t e);
    int n_slots;
    int n_cams;
    int slot;
    bit found;
    bit all_cams;
    longint sum;
    longint best;
    n_slots = (slots_reg == 0) ? 1 :
              ((slots_reg > mcwa_pkg::MAX_SLOTS) ? mcwa_pkg::MAX_SLOTS : int'(slots_reg));
    n_cams = int'(lastcam_reg) + 1;
    if (n_cams > mcwa_pkg::CAMERAS) n_cams = mcwa_pkg::CAMERAS;
    slot = int'(r.image_index) % n_slots;
    if (r.camera < mcwa_pkg::CAMERAS) begin
      pix_shadow[slot * mcwa_pkg::CAMERAS + r.camera] = r.width_pix;
      scaled_shadow[slot * mcwa_pkg::CAMERAS + r.camera] =
        40'(r.width_pix) * 40'(res_reg[r.camera]);
    end
    found = 1'b0;
    for (int s = 0; s < n_slots; s++) begin
      all_cams = 1'b1;
      for (int c = 0; c < n_cams; c++)
        if (pix_shadow[s * mcwa_pkg::CAMERAS + c] == 0) all_cams = 1'b0;
      if (all_cams) found = 1'b1;
    end
    if (found) begin
      best = 0;
      for (int s = 0; s < n_slots; s++) begin
        sum = longint'(overlap_reg);
        for (int c = 0; c < n_cams; c++)
          sum += longint'({24'b0, scaled_shadow[s * mcwa_pkg::CAMERAS + c]});
        if (s == 0 || sum > best) best = sum;
      end
      if (best > SAT_HI) best = SAT_HI;
      if (best < SAT_LO) best = SAT_LO;
      held_width = 43'(best);
    end
    e.total_width = held_width;
    e.width_echo = r.width_pix;
    e.complete_found = found;
  endtask

  // result checker
  always @(posedge clk) begin
    mcwa_pkg::result_t e;
    if (!rst && result_valid) begin
      if (pending_widths.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_widths.pop_front();
        if (result.total_width !== e.total_width) begin
          $error("total_width expected %0d actual %0d", e.total_width, result.total_width);
          errors++;
        end
        if (result.width_echo !== e.width_echo) begin
          $error("width_echo expected %0d actual %0d", e.width_echo, result.width_echo);
          errors++;
        end
        if (result.complete_found !== e.complete_found) begin
          $error("complete_found expected %0d actual %0d", e.complete_found,
                 result.complete_found);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // send one request, called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [15:0] idx, input logic [1:0] cam,
                              input logic [15:0] wpix);
    mcwa_pkg::result_t e;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    req.image_index = idx;
    req.camera = cam;
    req.width_pix = wpix;
    start = 1'b1;
    do @(posedge clk); while (busy);
    aggregate_width(req, e);
    pending_widths.push_back(e);
    @(negedge clk);
  endtask

  // wait until every result is back and the block is idle
  task automatic drain;
    start = 1'b0;
    while (pending_widths.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb register write, only while idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      mcwa_pkg::REG_SLOTS:   slots_reg = val[5:0];
      mcwa_pkg::REG_LASTCAM: lastcam_reg = val[1:0];
      mcwa_pkg::REG_RES0:    res_reg[0] = val[23:0];
      mcwa_pkg::REG_RES1:    res_reg[1] = val[23:0];
      mcwa_pkg::REG_RES2:    res_reg[2] = val[23:0];
      mcwa_pkg::REG_RES3:    res_reg[3] = val[23:0];
      mcwa_pkg::REG_OVERLAP: overlap_reg = val[39:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // defaults: one slot, camera 0 only, unit resolution
  task automatic test_defaults;
    send_request(16'd0, 2'd1, 16'd77);
    send_request(16'd5, 2'd0, 16'd0);
    send_request(16'd9, 2'd0, 16'd1234);
    send_request(16'hffff, 2'd3, 16'hffff);
  endtask

  // field extremes, all cameras, zero measurement
  task automatic test_extremes;
    write_reg(mcwa_pkg::REG_SLOTS, 64'd4);
    write_reg(mcwa_pkg::REG_LASTCAM, 64'd3);
    write_reg(mcwa_pkg::REG_RES0, 64'hffffff);
    write_reg(mcwa_pkg::REG_RES1, 64'd0);
    write_reg(mcwa_pkg::REG_RES2, 64'h8000);
    write_reg(mcwa_pkg::REG_RES3, 64'h10000);
    write_reg(mcwa_pkg::REG_OVERLAP, 64'h80_0000_0000);
    for (int c = 0; c < 4; c++) send_request(16'd2, 2'(c), 16'hffff);
    send_request(16'd6, 2'd1, 16'd0);
    send_request(16'hfffe, 2'd1, 16'd1);
  endtask

  // slot count of zero and above maximum, stale slots, saturation
  task automatic test_slots_and_saturation;
    write_reg(mcwa_pkg::REG_SLOTS, 64'd0);
    send_request(16'd3, 2'd1, 16'd5);
    write_reg(mcwa_pkg::REG_SLOTS, 64'd63);
    send_request(16'd40, 2'd0, 16'd9);
    write_reg(mcwa_pkg::REG_SLOTS, 64'd32);
    send_request(16'd31, 2'd2, 16'd100);
    write_reg(mcwa_pkg::REG_SLOTS, 64'd2);
    send_request(16'd1, 2'd0, 16'd3);
    write_reg(mcwa_pkg::REG_RES1, 64'hffffff);
    write_reg(mcwa_pkg::REG_RES2, 64'hffffff);
    write_reg(mcwa_pkg::REG_RES3, 64'hffffff);
    write_reg(mcwa_pkg::REG_OVERLAP, 64'h7f_ffff_ffff);
    write_reg(mcwa_pkg::REG_SLOTS, 64'd1);
    for (int c = 0; c < 4; c++) send_request(16'd7, 2'(c), 16'hffff);
  endtask

  function automatic logic [15:0] pick_width;
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hffff;
    if (r < 60) return 16'($urandom_range(300, 1));
    return 16'($urandom);
  endfunction

  // random settings with extremes mixed in
  task automatic random_config;
    int k;
    k = $urandom_range(9);
    case (k)
      0: write_reg(mcwa_pkg::REG_SLOTS, 64'd0);
      1: write_reg(mcwa_pkg::REG_SLOTS, 64'd1);
      2: write_reg(mcwa_pkg::REG_SLOTS, 64'd32);
      3: write_reg(mcwa_pkg::REG_SLOTS, 64'd63);
      4, 5: write_reg(mcwa_pkg::REG_SLOTS, 64'($urandom_range(63)));
      default: write_reg(mcwa_pkg::REG_SLOTS, 64'($urandom_range(6, 1)));
    endcase
    write_reg(mcwa_pkg::REG_LASTCAM, 64'($urandom_range(3)));
    for (int c = 0; c < 4; c++) begin
      k = $urandom_range(9);
      if (k == 0) write_reg(3'(mcwa_pkg::REG_RES0 + c), 64'd0);
      else if (k == 1) write_reg(3'(mcwa_pkg::REG_RES0 + c), 64'hffffff);
      else write_reg(3'(mcwa_pkg::REG_RES0 + c), 64'($urandom_range(24'hffffff)));
    end
    k = $urandom_range(5);
    if (k == 0) write_reg(mcwa_pkg::REG_OVERLAP, 64'h80_0000_0000);
    else if (k == 1) write_reg(mcwa_pkg::REG_OVERLAP, 64'h7f_ffff_ffff);
    else write_reg(mcwa_pkg::REG_OVERLAP, {24'b0, 8'($urandom), 32'($urandom)});
  endtask

  // random traffic in blocks, new settings between blocks
  task automatic test_random(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      random_config();
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(9) < 7)
          send_request(16'($urandom_range(40)), 2'($urandom), pick_width());
        else
          send_request(16'($urandom), 2'($urandom), pick_width());
        if ($urandom_range(199) == 0) drain();
      end
      sent += 50;
    end
  endtask

  initial begin
    for (int i = 0; i < mcwa_pkg::DEPTH; i++) begin
      pix_shadow[i] = '0;
      scaled_shadow[i] = '0;
    end
    held_width = '0;
    slots_reg = 6'd1;
    lastcam_reg = 2'd0;
    for (int c = 0; c < 4; c++) res_reg[c] = 24'd65536;
    overlap_reg = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_extremes();
    test_slots_and_saturation();
    idle_pct = 14;
    test_random(450);
    idle_pct = 86;
    test_random(450);
    drain();
    idle_pct = 0;
    test_random(450);
    drain();
    repeat (300) @(negedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire
